// ===== hw/rtl/cmacc_pkg.sv =====
// Shared types, codes and defaults for the confusion matrix accumulator.
package cmacc_pkg;

  // Default sizing of the count store.
  localparam int MAX_CLASSES_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;

  // Input word modes, also used as result kinds.
  localparam logic [1:0] MODE_ELEMENT = 2'd0;
  localparam logic [1:0] MODE_CLEAR   = 2'd1;
  localparam logic [1:0] MODE_CELL    = 2'd2;
  localparam logic [1:0] MODE_STATS   = 2'd3;

  // Register index as decoded from paddr bit 2.
  localparam logic REG_THRESHOLD   = 1'b0;
  localparam logic REG_CLASS_COUNT = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_CELL,
    ST_WALK,
    ST_DRAIN,
    ST_PSTART,
    ST_PWAIT,
    ST_RSTART,
    ST_RWAIT,
    ST_EMIT
  } state_t;

  // What the memory read issued last cycle was for.
  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_DIAG,
    TAG_COL,
    TAG_ROW
  } read_tag_t;

endpackage

// ===== hw/rtl/cmacc_mem.sv =====
// Count store: one write port, one read port with registered read data.
module cmacc_mem #(
  parameter int AW = 9,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cmacc_div.sv =====
// Restoring divider giving floor(num * 2^16 / den) as unsigned Q1.16, capped at 1.0, one bit a cycle.
module cmacc_div #(
  parameter int DW = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DW-1:0]       num,
  input  logic [DW-1:0]       den,
  output logic                done,
  output logic [16:0]         quot
);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [15:0]   q;
  logic [4:0]    cnt;
  logic          busy;
  logic [DW:0]   rem2;
  logic          fits;

  // One trial subtraction per cycle.
  assign rem2 = {rem, 1'b0};
  assign fits = rem2 >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // A ratio of one or more is capped at 1.0 right away.
        if (num >= den) begin
          quot <= 17'h10000;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
        rem <= num;
        dsr <= den;
        q   <= '0;
        cnt <= 5'd16;
      end else if (busy) begin
        if (fits) begin
          rem <= DW'(rem2 - {1'b0, dsr});
        end else begin
          rem <= DW'(rem2);
        end
        q   <= {q[14:0], fits};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= {1'b0, q[14:0], fits};
        end
      end
    end
  end

  // The divider is only started while idle.
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

endmodule

// ===== hw/rtl/confusion_matrix_accumulator_unit.sv =====
// Confusion matrix accumulator with reject column, sequencer around one count memory.
//
//  Channel | Direction | Handshake                       | Content
//  s       | in        | s_tvalid / s_tready             | mode, sample fields, s_tlast
//  m       | out       | m_tvalid / m_tready             | result kind and result fields
//  apb     | in        | psel & penable & pwrite & pready| threshold, class_count
//
// A certainty element that does not end a sample is taken in the idle state. A sample end
// and a cell read each pass through one memory read-modify-write or read state, skipped
// when the true class, row or column is out of range. Statistics walk the memory, one read
// a cycle, then divide for precision and recall, each divide skipped when its total is zero;
// a row out of range skips the walk and both divides. A clear sweeps every memory entry, one
// a cycle, and the same sweep runs after reset, during which no word is accepted. A stalled
// output word holds the block in its emit state; configuration writes are taken at any time.
module confusion_matrix_accumulator_unit #(
  parameter int MAX_CLASSES = cmacc_pkg::MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = cmacc_pkg::COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // true_class[3:0], certainty[19:4], row_index[23:20], column_index[28:24], zero[31:29]
  input  logic [31:0]  s_tdata,
  // mode[1:0]
  input  logic [1:0]   s_tuser,
  input  logic         s_tlast,
  // Output stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // predicted_class[4:0], cell_count[36:5], column_total[68:37], row_total[100:69],
  // precision_value[117:101], recall_value[134:118], precision_undefined[135],
  // recall_undefined[136], zero[143:137]
  output logic [143:0] m_tdata,
  // result_kind[1:0]
  output logic [1:0]   m_tuser,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW   = $clog2(MAX_CLASSES + 1);
  localparam int RW   = $clog2(MAX_CLASSES);
  localparam int AW   = RW + CW;
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam int DW   = COUNT_BITS;

  // Input fields.
  logic [1:0]         in_mode;
  logic [3:0]         in_tclass;
  logic signed [15:0] in_cert;
  logic [3:0]         in_row;
  logic [4:0]         in_col;
  logic               accept;

  assign in_mode   = s_tuser;
  assign in_tclass = s_tdata[3:0];
  assign in_cert   = s_tdata[19:4];
  assign in_row    = s_tdata[23:20];
  assign in_col    = s_tdata[28:24];

  // Configuration registers.
  logic signed [15:0] threshold;
  logic [4:0]         class_count;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= '0;
      class_count <= 5'd16;
    end else if (cfg_write) begin
      unique case (paddr[2])
        cmacc_pkg::REG_THRESHOLD:   threshold   <= pwdata[15:0];
        cmacc_pkg::REG_CLASS_COUNT: class_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cmacc_pkg::REG_THRESHOLD:   prdata = {16'b0, threshold};
      cmacc_pkg::REG_CLASS_COUNT: prdata = {27'b0, class_count};
      default:                    prdata = '0;
    endcase
  end

  // Classes in use, clamped to the range 1 to the store size.
  logic [CMPW-1:0] cc_ext;
  logic [CMPW-1:0] nc;

  assign cc_ext = CMPW'(class_count);
  always_comb begin
    if (cc_ext == '0) begin
      nc = CMPW'(1);
    end else if (cc_ext > CMPW'(MAX_CLASSES)) begin
      nc = CMPW'(MAX_CLASSES);
    end else begin
      nc = cc_ext;
    end
  end

  // Sequencer and datapath registers.
  cmacc_pkg::state_t    state, state_next;
  cmacc_pkg::read_tag_t rd_tag, rd_tag_next;
  logic               clr_emit;
  logic [AW-1:0]      sweep;
  logic signed [15:0] best_cert;
  logic [4:0]         best_col;
  logic [4:0]         elem_pos;
  logic [AW-1:0]      upd_addr;
  logic [RW-1:0]      srow;
  logic [CMPW-1:0]    k;
  logic               phase;
  logic [DW-1:0]      diag, csum, rsum;
  logic [1:0]         res_kind;
  logic [4:0]         res_pred;
  logic [DW-1:0]      res_cell;
  logic [16:0]        res_prec, res_rec;
  logic               res_pu, res_ru;
  logic               out_free;

  // Memory ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  // Divider.
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_den;
  logic [16:0]   div_quot;

  assign s_tready = (state == cmacc_pkg::ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Running argmax including the current element.
  logic               pos_ok, take;
  logic signed [15:0] new_best;
  logic [4:0]         new_bcol;
  logic [CMPW-1:0]    pred;
  logic               tclass_ok, cell_ok, srow_ok;

  assign pos_ok    = CMPW'(elem_pos) < nc;
  assign take      = pos_ok && ((elem_pos == '0) || (in_cert > best_cert));
  assign new_best  = take ? in_cert : best_cert;
  assign new_bcol  = take ? elem_pos : best_col;
  assign pred      = (new_best >= threshold) ? CMPW'(new_bcol) : nc;
  assign tclass_ok = CMPW'(in_tclass) < nc;
  assign cell_ok   = (CMPW'(in_row) < nc) && (CMPW'(in_col) <= nc);
  assign srow_ok   = CMPW'(in_row) < nc;

  // Saturating add of a memory word.
  function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DW] ? {DW{1'b1}} : s[DW-1:0];
  endfunction

  // Next state, memory and divider controls.
  always_comb begin
    state_next  = state;
    rd_tag_next = cmacc_pkg::TAG_NONE;
    mem_we      = 1'b0;
    mem_waddr   = upd_addr;
    mem_wdata   = '0;
    mem_raddr   = upd_addr;
    div_start   = 1'b0;
    div_den     = csum;
    unique case (state)
      cmacc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
        if (sweep == {AW{1'b1}}) begin
          state_next = clr_emit ? cmacc_pkg::ST_EMIT : cmacc_pkg::ST_IDLE;
        end
      end
      cmacc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            cmacc_pkg::MODE_ELEMENT: begin
              mem_raddr = {RW'(in_tclass), CW'(pred)};
              if (s_tlast) begin
                state_next = tclass_ok ? cmacc_pkg::ST_UPDATE : cmacc_pkg::ST_EMIT;
              end
            end
            cmacc_pkg::MODE_CLEAR: state_next = cmacc_pkg::ST_CLEAR;
            cmacc_pkg::MODE_CELL: begin
              mem_raddr  = {RW'(in_row), CW'(in_col)};
              state_next = cell_ok ? cmacc_pkg::ST_CELL : cmacc_pkg::ST_EMIT;
            end
            default: begin
              mem_raddr = {RW'(in_row), CW'(in_row)};
              if (srow_ok) begin
                rd_tag_next = cmacc_pkg::TAG_DIAG;
                state_next  = cmacc_pkg::ST_WALK;
              end else begin
                state_next  = cmacc_pkg::ST_EMIT;
              end
            end
          endcase
        end
      end
      cmacc_pkg::ST_UPDATE: begin
        mem_we     = 1'b1;
        mem_wdata  = (mem_rdata == {DW{1'b1}}) ? mem_rdata : mem_rdata + DW'(1);
        state_next = cmacc_pkg::ST_EMIT;
      end
      cmacc_pkg::ST_CELL: state_next = cmacc_pkg::ST_EMIT;
      cmacc_pkg::ST_WALK: begin
        if (!phase) begin
          mem_raddr   = {RW'(k), CW'(srow)};
          rd_tag_next = cmacc_pkg::TAG_COL;
        end else begin
          mem_raddr   = {srow, CW'(k)};
          rd_tag_next = cmacc_pkg::TAG_ROW;
          if (k == nc - CMPW'(1)) begin
            state_next = cmacc_pkg::ST_DRAIN;
          end
        end
      end
      cmacc_pkg::ST_DRAIN: state_next = cmacc_pkg::ST_PSTART;
      cmacc_pkg::ST_PSTART: begin
        div_start  = (csum != '0);
        state_next = (csum != '0) ? cmacc_pkg::ST_PWAIT : cmacc_pkg::ST_RSTART;
      end
      cmacc_pkg::ST_PWAIT: begin
        if (div_done) begin
          state_next = cmacc_pkg::ST_RSTART;
        end
      end
      cmacc_pkg::ST_RSTART: begin
        div_den    = rsum;
        div_start  = (rsum != '0);
        state_next = (rsum != '0) ? cmacc_pkg::ST_RWAIT : cmacc_pkg::ST_EMIT;
      end
      cmacc_pkg::ST_RWAIT: begin
        div_den = rsum;
        if (div_done) begin
          state_next = cmacc_pkg::ST_EMIT;
        end
      end
      cmacc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = cmacc_pkg::ST_IDLE;
        end
      end
      default: state_next = cmacc_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= cmacc_pkg::ST_CLEAR;
      rd_tag <= cmacc_pkg::TAG_NONE;
    end else begin
      state  <= state_next;
      rd_tag <= rd_tag_next;
    end
  end

  // Argmax state and sweep control.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_cert <= '0;
      best_col  <= '0;
      elem_pos  <= '0;
      sweep     <= '0;
      clr_emit  <= 1'b0;
    end else begin
      if (state == cmacc_pkg::ST_CLEAR) begin
        sweep <= sweep + AW'(1);
      end
      if (accept && in_mode == cmacc_pkg::MODE_ELEMENT) begin
        if (s_tlast) begin
          best_cert <= '0;
          best_col  <= '0;
          elem_pos  <= '0;
        end else begin
          best_cert <= new_best;
          best_col  <= new_bcol;
          if (elem_pos != 5'd31) begin
            elem_pos <= elem_pos + 5'd1;
          end
        end
      end else if (accept && in_mode == cmacc_pkg::MODE_CLEAR) begin
        best_cert <= '0;
        best_col  <= '0;
        elem_pos  <= '0;
        sweep     <= '0;
        clr_emit  <= 1'b1;
      end
    end
  end

  // Result fields, statistics walk and accumulation.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_kind <= in_mode;
      res_pred <= (in_mode == cmacc_pkg::MODE_ELEMENT) ? 5'(pred) : '0;
      res_cell <= '0;
      res_prec <= '0;
      res_rec  <= '0;
      res_pu   <= (in_mode == cmacc_pkg::MODE_STATS) && !srow_ok;
      res_ru   <= (in_mode == cmacc_pkg::MODE_STATS) && !srow_ok;
      csum     <= '0;
      rsum     <= '0;
      diag     <= '0;
      k        <= '0;
      phase    <= 1'b0;
      srow     <= RW'(in_row);
      upd_addr <= {RW'(in_tclass), CW'(pred)};
    end
    if (state == cmacc_pkg::ST_WALK) begin
      phase <= !phase;
      if (phase) begin
        k <= k + CMPW'(1);
      end
    end
    if (state == cmacc_pkg::ST_CELL) begin
      res_cell <= DW'(mem_rdata);
    end
    case (rd_tag)
      cmacc_pkg::TAG_DIAG: diag <= mem_rdata;
      cmacc_pkg::TAG_COL:  csum <= sat_add(csum, mem_rdata);
      cmacc_pkg::TAG_ROW:  rsum <= sat_add(rsum, mem_rdata);
      default: ;
    endcase
    if (state == cmacc_pkg::ST_PSTART) begin
      res_cell <= diag;
      res_pu   <= (csum == '0);
    end
    if (state == cmacc_pkg::ST_RSTART) begin
      res_ru <= (rsum == '0);
    end
    if (state == cmacc_pkg::ST_PWAIT && div_done) begin
      res_prec <= div_quot;
    end
    if (state == cmacc_pkg::ST_RWAIT && div_done) begin
      res_rec <= div_quot;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == cmacc_pkg::ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cmacc_pkg::ST_EMIT && out_free) begin
      m_tuser <= res_kind;
      m_tdata <= {7'b0, res_ru, res_pu, res_rec, res_prec,
                  32'(rsum & {DW{res_kind == cmacc_pkg::MODE_STATS}}),
                  32'(csum & {DW{res_kind == cmacc_pkg::MODE_STATS}}),
                  32'(res_cell), res_pred};
    end
  end

  cmacc_mem #(
    .AW(AW),
    .DW(DW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  cmacc_div #(
    .DW(DW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (diag),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  // The count store is only written by the sweep or a sample update.
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == cmacc_pkg::ST_CLEAR || state == cmacc_pkg::ST_UPDATE))
    else $error("count store written outside sweep or update");

  // An update always follows the accept of a sample end.
  a_update_order: assert property (@(posedge clk) disable iff (rst)
    state == cmacc_pkg::ST_UPDATE |-> $past(state) == cmacc_pkg::ST_IDLE)
    else $error("update without preceding accept");

  // Divider results arrive only while they are awaited.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == cmacc_pkg::ST_PWAIT || state == cmacc_pkg::ST_RWAIT))
    else $error("unexpected divider result");

endmodule

// ===== sim/cmacc_checker.sv =====
// Checker for the confusion matrix accumulator: predicts every result word and compares it.
`timescale 1ns / 1ps

module cmacc_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [31:0]  s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [143:0] m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  pred;
    logic [31:0] cell_val;
    logic [31:0] col_sum;
    logic [31:0] row_sum;
    logic [16:0] prec;
    logic [16:0] rec;
    logic        prec_undef;
    logic        rec_undef;
  } result_t;

  // Model copy of the block state and its registers.
  logic [31:0]        counts [16][17];
  logic signed [15:0] best_cert;
  logic [4:0]         best_col;
  logic [4:0]         position;
  logic signed [15:0] threshold;
  logic [4:0]         class_count;

  result_t expected_results[$];
  int      fails = 0;

  function automatic logic [4:0] classes_in_use(input logic [4:0] cc);
    if (cc == 0) return 5'd1;
    if (cc > 16) return 5'd16;
    return cc;
  endfunction

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Truncated Q1.16 ratio; a numerator at or above the divisor gives 1.0.
  function automatic logic [16:0] ratio_q16(input logic [31:0] n, input logic [31:0] d);
    logic [47:0] q;
    if (n >= d) return 17'd65536;
    q = {n, 16'd0} / {16'd0, d};
    return q[16:0];
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fails < 40)
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  task automatic clear_counts();
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 17; c++)
        counts[r][c] = '0;
  endtask

  // Work out the result word that one accepted input word causes, if any.
  task automatic predict(input logic [1:0] mode, input logic [31:0] d);
    logic [3:0]         tc;
    logic signed [15:0] cert;
    logic [3:0]         row;
    logic [4:0]         col;
    logic [4:0]         nc;
    logic [4:0]         pick;
    logic [31:0]        cs;
    logic [31:0]        rs;
    result_t            r;
    tc   = d[3:0];
    cert = d[19:4];
    row  = d[23:20];
    col  = d[28:24];
    nc   = classes_in_use(class_count);
    r    = '0;
    r.kind = mode;
    case (mode)
      cmacc_pkg::MODE_ELEMENT: begin
        if (position < nc && (position == 0 || cert > best_cert)) begin
          best_cert = cert;
          best_col  = position;
        end
        if (position < 31) position++;
        if (!s_tlast) return;
        pick = (best_cert >= threshold) ? best_col : nc;
        if (tc < nc && counts[tc][pick] != 32'hFFFF_FFFF)
          counts[tc][pick]++;
        r.pred = pick;
        best_cert = '0;
        best_col  = '0;
        position  = '0;
      end
      cmacc_pkg::MODE_CLEAR: begin
        clear_counts();
        best_cert = '0;
        best_col  = '0;
        position  = '0;
      end
      cmacc_pkg::MODE_CELL: begin
        if (row < nc && col <= nc) r.cell_val = counts[row][col];
      end
      default: begin
        if (row >= nc) begin
          r.prec_undef = 1'b1;
          r.rec_undef  = 1'b1;
        end else begin
          cs = '0;
          rs = '0;
          for (int k = 0; k < nc; k++) begin
            cs = sat_sum(cs, counts[k][row]);
            rs = sat_sum(rs, counts[row][k]);
          end
          r.cell_val = counts[row][row];
          r.col_sum  = cs;
          r.row_sum  = rs;
          if (cs == 0) r.prec_undef = 1'b1;
          else r.prec = ratio_q16(counts[row][row], cs);
          if (rs == 0) r.rec_undef = 1'b1;
          else r.rec = ratio_q16(counts[row][row], rs);
        end
      end
    endcase
    expected_results.push_back(r);
  endtask

  // Compare one accepted result word with the oldest expectation.
  task automatic compare_word();
    result_t e;
    if (expected_results.size() == 0) begin
      report("unexpected word", m_tdata[31:0], '0);
      return;
    end
    e = expected_results.pop_front();
    if (m_tuser != e.kind) report("result_kind", m_tuser, e.kind);
    if (m_tdata[4:0] != e.pred) report("predicted_class", m_tdata[4:0], e.pred);
    if (m_tdata[36:5] != e.cell_val) report("cell_count", m_tdata[36:5], e.cell_val);
    if (m_tdata[68:37] != e.col_sum) report("column_total", m_tdata[68:37], e.col_sum);
    if (m_tdata[100:69] != e.row_sum) report("row_total", m_tdata[100:69], e.row_sum);
    if (m_tdata[117:101] != e.prec) report("precision_value", m_tdata[117:101], e.prec);
    if (m_tdata[134:118] != e.rec) report("recall_value", m_tdata[134:118], e.rec);
    if (m_tdata[135] != e.prec_undef)
      report("precision_undefined", m_tdata[135], e.prec_undef);
    if (m_tdata[136] != e.rec_undef) report("recall_undefined", m_tdata[136], e.rec_undef);
    if (m_tdata[143:137] != '0) report("padding", m_tdata[143:137], '0);
  endtask

  // Watch the register port and both streams at every edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_counts();
      best_cert   = '0;
      best_col    = '0;
      position    = '0;
      threshold   = '0;
      class_count = 5'd16;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == cmacc_pkg::REG_THRESHOLD) threshold = pwdata[15:0];
        else class_count = pwdata[4:0];
      end
      if (m_tvalid && m_tready) compare_word();
      if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
    end
    fail_count <= fails;
    pending    <= expected_results.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives samples, reads and register writes into the accumulator.
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           fail_count;
  int           pending;
  logic         hold_req = 1'b0;
  int           words_sent = 0;
  int           idle_cycles = 0;
  logic [4:0]   cur_classes = 5'd16;

  confusion_matrix_accumulator_unit dut (.*);

  cmacc_checker u_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Idle gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one input word after a random gap and wait until it is taken.
  task automatic send(input logic [1:0] mode, input logic [3:0] tc, input logic [15:0] cert,
                      input logic last, input logic [3:0] row, input logic [4:0] col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser  <= mode;
    s_tlast  <= last;
    s_tdata  <= {3'b000, col, row, cert, tc};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    words_sent++;
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Let every expected word arrive, plus a margin for elements still in flight.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] thr, input logic [4:0] cc);
    drain();
    apb_write(3'd0, {{16{thr[15]}}, thr});
    apb_write(3'd4, {27'd0, cc});
    cur_classes = (cc == 0) ? 5'd1 : (cc > 16) ? 5'd16 : cc;
  endtask

  function automatic logic [15:0] rand_cert();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r < 4) return 16'($urandom_range(0, 3)) - 16'd1;
    return 16'($urandom);
  endfunction

  // One sample of certainty elements; ties come from repeating the last value.
  task automatic send_sample(input int len, input logic [3:0] tc);
    logic [15:0] c;
    c = rand_cert();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) != 0) c = rand_cert();
      send(cmacc_pkg::MODE_ELEMENT, tc, c, i == len - 1, 4'($urandom), 5'($urandom));
    end
  endtask

  // Mostly well-formed samples, with reads, statistics, rare clears and broken samples.
  task automatic random_phase(input int target);
    int r;
    int len;
    while (words_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = cur_classes;
        send_sample(len, $urandom_range(0, 99) < 85 ? 4'($urandom_range(0, cur_classes - 1))
                                                    : 4'($urandom));
      end else if (r < 68) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 20);
        send_sample(len, 4'($urandom));
      end else if (r < 80) begin
        send(cmacc_pkg::MODE_CELL, 4'($urandom), 16'($urandom), 1'($urandom),
             4'($urandom_range(0, 15)),
             $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(0, cur_classes)));
      end else if (r < 92) begin
        send(cmacc_pkg::MODE_STATS, 4'($urandom), 16'($urandom), 1'($urandom),
             4'($urandom_range(0, 15)), 5'($urandom));
      end else if (r < 93) begin
        send(cmacc_pkg::MODE_CLEAR, 4'($urandom), 16'($urandom), 1'($urandom),
             4'($urandom), 5'($urandom));
      end else begin
        send(cmacc_pkg::MODE_ELEMENT, 4'($urandom), rand_cert(), 1'b0, 4'($urandom),
             5'($urandom));
      end
    end
  endtask

  // Receiver: random ready runs, and one long hold-off on request.
  initial begin
    int   run;
    logic held;
    run  = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        held = 1'b1;
        run  = 0;
      end else if (run > 0) begin
        run--;
      end else if ($urandom_range(0, 1) == 0) begin
        m_tready <= 1'b1;
        run = $urandom_range(0, 8);
      end else begin
        m_tready <= 1'b0;
        run = pick_gap();
      end
    end
  end

  // Watchdog on cycles in which neither stream moves a word.
  initial begin
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part with three classes in use.
    configure(16'd0, 5'd3);
    send(cmacc_pkg::MODE_CLEAR, 4'd0, 16'd0, 1'b1, 4'd0, 5'd0);
    // Extremes; the first of two equal maxima wins.
    send(cmacc_pkg::MODE_ELEMENT, 4'd0, 16'h8000, 1'b0, 4'd0, 5'd0);
    send(cmacc_pkg::MODE_ELEMENT, 4'd0, 16'h7FFF, 1'b0, 4'd0, 5'd0);
    send(cmacc_pkg::MODE_ELEMENT, 4'd0, 16'h7FFF, 1'b1, 4'd0, 5'd0);
    // All below the threshold lands in the unknown column.
    send(cmacc_pkg::MODE_ELEMENT, 4'd1, 16'hFFFF, 1'b0, 4'd0, 5'd0);
    send(cmacc_pkg::MODE_ELEMENT, 4'd1, 16'hFFFE, 1'b1, 4'd0, 5'd0);
    // True class out of range, and elements past the class count.
    send(cmacc_pkg::MODE_ELEMENT, 4'd15, 16'd100, 1'b1, 4'd0, 5'd0);
    send_sample(6, 4'd2);
    send(cmacc_pkg::MODE_CELL, 4'd0, 16'd0, 1'b0, 4'd0, 5'd1);
    send(cmacc_pkg::MODE_CELL, 4'd0, 16'd0, 1'b0, 4'd1, 5'd3);
    send(cmacc_pkg::MODE_CELL, 4'd0, 16'd0, 1'b0, 4'd3, 5'd0);
    send(cmacc_pkg::MODE_CELL, 4'd0, 16'd0, 1'b0, 4'd0, 5'd4);
    send(cmacc_pkg::MODE_CELL, 4'hF, 16'hFFFF, 1'b1, 4'hF, 5'h1F);
    send(cmacc_pkg::MODE_STATS, 4'd0, 16'd0, 1'b0, 4'd0, 5'd0);
    send(cmacc_pkg::MODE_STATS, 4'd0, 16'd0, 1'b0, 4'd1, 5'd0);
    send(cmacc_pkg::MODE_STATS, 4'd0, 16'd0, 1'b0, 4'd2, 5'd0);
    send(cmacc_pkg::MODE_STATS, 4'd0, 16'd0, 1'b0, 4'd15, 5'd0);
    // A partial sample abandoned by a clear, then statistics on an empty store.
    send(cmacc_pkg::MODE_ELEMENT, 4'd0, 16'd5, 1'b0, 4'd0, 5'd0);
    send(cmacc_pkg::MODE_CLEAR, 4'd0, 16'd0, 1'b0, 4'd0, 5'd0);
    send(cmacc_pkg::MODE_STATS, 4'd0, 16'd0, 1'b0, 4'd0, 5'd0);

    // Random phases over several register settings; the first one includes the hold-off.
    configure(16'd0, 5'd16);
    hold_req <= 1'b1;
    random_phase(300);
    configure(16'h8000, 5'd1);
    random_phase(450);
    configure(16'h7FFF, 5'd4);
    random_phase(650);
    configure(16'($urandom), 5'd31);
    random_phase(850);
    configure(16'($urandom_range(0, 8000)), 5'd0);
    random_phase(950);
    configure(16'd1000, 5'd7);
    random_phase(1200);
    configure(16'hEC78, 5'd16);
    random_phase(1450);

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cmacc_pkg.sv
hw/rtl/cmacc_mem.sv
hw/rtl/cmacc_div.sv
hw/rtl/confusion_matrix_accumulator_unit.sv
sim/cmacc_checker.sv
sim/tb.sv
